/* hdl/cmf_pkg.sv */
// ----------------------------------------------------------------------------
// cmf_pkg: shared definitions for the five-point cross mean filter
// Widths, register indexes, item codes, controller states, the command
// bundle from controller to datapath, and the constant-divisor helpers.
// ----------------------------------------------------------------------------
package cmf_pkg;

    localparam int CMF_MAX_COLS = 64;
    localparam int CMF_MAX_ROWS = 1024;

    localparam int SAMPLE_W    = 16;
    localparam int MEAN_W      = 24;
    localparam int SUM_W       = 19;  // five samples of 16 bits
    localparam int CNT_W       = 3;   // pixel count 1..5
    localparam int K_W         = 9;   // integer part of 256 / count
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int ROWS_CFG_W  = 11;
    localparam int COLS_CFG_W  = 7;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 11'd10;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // Input word codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_C,
        ST_RD_L,
        ST_RD_R,
        ST_SUM_R,
        ST_MUL,
        ST_FIN,
        ST_WR
    } t_state;

    // Properties of the word in work, fixed at acceptance.
    typedef struct packed {
        logic             use_sample;
        logic             has_up;
        logic             has_left;
        logic             has_right;
        logic             sel;
        logic             frame_end;
        logic [CNT_W-1:0] count;
    } t_job;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_sample;
        logic wr_en;
        logic sum_init;
        logic acc_center;
        logic acc_left;
        logic acc_right;
        logic mul;
        logic fin;
        t_job job;
    } t_dp_cmd;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // floor(256 * s / n) = scale_of(n) * s + floor(s / n) for n = 3 and 5,
    // and scale_of(n) * s alone for n = 1, 2 and 4.
    function automatic logic [K_W-1:0] scale_of(input logic [CNT_W-1:0] n);
        logic [K_W-1:0] k;
        unique case (n)
            3'd1:    k = 9'd256;
            3'd2:    k = 9'd128;
            3'd3:    k = 9'd85;
            3'd4:    k = 9'd64;
            3'd5:    k = 9'd51;
            default: k = 9'd0;
        endcase
        return k;
    endfunction

    // floor(2^20 / n) for the two divisors that leave a fraction.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        unique case (n)
            3'd3:    m = 20'd349525;
            3'd5:    m = 20'd209715;
            default: m = 20'd0;
        endcase
        return m;
    endfunction

    function automatic logic has_frac(input logic [CNT_W-1:0] n);
        return (n == 3'd3) || (n == 3'd5);
    endfunction

endpackage

/* hdl/cmf_datapath.sv */
// ----------------------------------------------------------------------------
// cmf_datapath: line stores, neighborhood sum and constant division
// Two line stores with separate read and write ports and registered reads,
// the accumulator and the reciprocal divider with its one-step correction.
// ----------------------------------------------------------------------------
module cmf_datapath #(
    parameter int MAX_COLS = cmf_pkg::CMF_MAX_COLS
) (
    input  logic                                  i_clk,
    input  logic [cmf_pkg::SAMPLE_W-1:0]          i_sample,
    input  cmf_pkg::t_dp_cmd                      i_cmd,
    input  logic [cmf_pkg::addr_w(MAX_COLS)-1:0]  i_rd_addr,
    input  logic [cmf_pkg::addr_w(MAX_COLS)-1:0]  i_wr_addr,
    output logic [cmf_pkg::MEAN_W-1:0]            o_mean_value
);
    import cmf_pkg::*;

    logic [SAMPLE_W-1:0] r_store_a [MAX_COLS];
    logic [SAMPLE_W-1:0] r_store_b [MAX_COLS];
    logic [SAMPLE_W-1:0] r_rd_a;
    logic [SAMPLE_W-1:0] r_rd_b;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    r_q_est;
    logic [MEAN_W-1:0]   r_mean;

    logic [SAMPLE_W-1:0]        w_new;
    logic [SAMPLE_W-1:0]        w_old;
    logic [SUM_W+RECIP_W-1:0]   w_prod;
    logic [SUM_W-1:0]           w_qd;
    logic [SUM_W-1:0]           w_rem;
    logic [SUM_W-1:0]           w_q;
    logic [SUM_W+K_W-1:0]       w_scaled;
    logic [SUM_W+K_W-1:0]       w_mean_full;

    // The select bit names the store holding the newest complete row.
    assign w_new = i_cmd.job.sel ? r_rd_b : r_rd_a;
    assign w_old = i_cmd.job.sel ? r_rd_a : r_rd_b;

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_store_a[i_rd_addr];
        r_rd_b <= r_store_b[i_rd_addr];
        if (i_cmd.wr_en) begin
            if (i_cmd.job.sel) begin
                r_store_a[i_wr_addr] <= r_sample;
            end else begin
                r_store_b[i_wr_addr] <= r_sample;
            end
        end
    end

    // Estimate is the true quotient or one below it.
    assign w_prod = r_sum * recip_of(i_cmd.job.count);
    assign w_qd   = SUM_W'(r_q_est * i_cmd.job.count);
    assign w_rem  = r_sum - w_qd;
    always_comb begin
        if (has_frac(i_cmd.job.count)) begin
            w_q = (w_rem >= SUM_W'(i_cmd.job.count)) ? r_q_est + SUM_W'(1) : r_q_est;
        end else begin
            w_q = '0;
        end
    end
    assign w_scaled    = r_sum * scale_of(i_cmd.job.count);
    assign w_mean_full = w_scaled + (SUM_W+K_W)'(w_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.sum_init) begin
            r_sum <= i_cmd.job.use_sample ? SUM_W'(r_sample) : '0;
        end else if (i_cmd.acc_center) begin
            r_sum <= r_sum + SUM_W'(w_new)
                     + (i_cmd.job.has_up ? SUM_W'(w_old) : '0);
        end else if (i_cmd.acc_left) begin
            r_sum <= r_sum + (i_cmd.job.has_left ? SUM_W'(w_new) : '0);
        end else if (i_cmd.acc_right) begin
            r_sum <= r_sum + (i_cmd.job.has_right ? SUM_W'(w_new) : '0);
        end
        if (i_cmd.mul) begin
            r_q_est <= w_prod[RECIP_SHIFT +: SUM_W];
        end
        if (i_cmd.fin) begin
            r_mean <= w_mean_full[MEAN_W-1:0];
        end
    end

    assign o_mean_value = r_mean;

endmodule

/* hdl/cmf_ctrl.sv */
// ----------------------------------------------------------------------------
// cmf_ctrl: frame position tracking and step sequencing
// Holds the configuration, the row and column position and the drain flag,
// sequences the datapath for each word and owns the output valid.
// ----------------------------------------------------------------------------
module cmf_ctrl #(
    parameter int MAX_COLS = cmf_pkg::CMF_MAX_COLS,
    parameter int MAX_ROWS = cmf_pkg::CMF_MAX_ROWS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_cmd,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cmf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cmf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [cmf_pkg::addr_w(MAX_ROWS)-1:0]  o_out_row,
    output logic [cmf_pkg::addr_w(MAX_COLS)-1:0]  o_out_col,
    output logic                                  o_frame_end,
    output cmf_pkg::t_dp_cmd                      o_dp_cmd,
    output logic [cmf_pkg::addr_w(MAX_COLS)-1:0]  o_rd_addr,
    output logic [cmf_pkg::addr_w(MAX_COLS)-1:0]  o_wr_addr
);
    import cmf_pkg::*;

    localparam int COL_W = addr_w(MAX_COLS);
    localparam int ROW_W = addr_w(MAX_ROWS);

    t_state                r_state, n_state;
    logic [ROWS_CFG_W-1:0] r_rows, n_rows;
    logic [COLS_CFG_W-1:0] r_cols, n_cols;
    logic [ROW_W-1:0]      r_row_pos, n_row_pos;
    logic [COL_W-1:0]      r_col_pos, n_col_pos;
    logic                  r_draining, n_draining;
    logic                  r_sel, n_sel;
    t_job                  r_job, n_job;
    logic [ROW_W-1:0]      r_job_row, n_job_row;
    logic [COL_W-1:0]      r_job_col, n_job_col;
    logic                  r_out_valid;
    logic [ROW_W-1:0]      r_out_row;
    logic [COL_W-1:0]      r_out_col;
    logic                  r_out_fe;

    logic             w_accept;
    logic             w_cfg_we;
    logic             w_go_work;
    logic             w_go_write;
    logic             w_out_free;
    logic             w_load_out;
    logic [ROW_W-1:0] w_last_row;
    logic [COL_W-1:0] w_last_col;

    // A configuration write wins over an input word offered in the same cycle.
    assign w_accept   = i_in_valid && (r_state == ST_IDLE) && !i_cfg_valid;
    assign w_cfg_we   = i_cfg_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_out = (r_state == ST_FIN) && w_out_free;

    // Register values are clamped to the supported frame size.
    always_comb begin
        if (r_rows == '0) begin
            w_last_row = '0;
        end else if (int'(r_rows) > MAX_ROWS) begin
            w_last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            w_last_row = ROW_W'(int'(r_rows) - 1);
        end
        if (r_cols == '0) begin
            w_last_col = '0;
        end else if (int'(r_cols) > MAX_COLS) begin
            w_last_col = COL_W'(MAX_COLS - 1);
        end else begin
            w_last_col = COL_W'(int'(r_cols) - 1);
        end
    end

    // Position bookkeeping and job capture at acceptance.
    always_comb begin
        n_rows     = r_rows;
        n_cols     = r_cols;
        n_row_pos  = r_row_pos;
        n_col_pos  = r_col_pos;
        n_draining = r_draining;
        n_sel      = r_sel;
        n_job      = r_job;
        n_job_row  = r_job_row;
        n_job_col  = r_job_col;
        w_go_work  = 1'b0;
        w_go_write = 1'b0;
        if (w_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROWS: n_rows = i_cfg_data[ROWS_CFG_W-1:0];
                REG_COLS: n_cols = i_cfg_data[COLS_CFG_W-1:0];
            endcase
            n_row_pos  = '0;
            n_col_pos  = '0;
            n_draining = 1'b0;
        end else if (w_accept) begin
            n_job_col          = r_col_pos;
            n_job.sel          = r_sel;
            n_job.has_left     = (r_col_pos != '0);
            n_job.has_right    = (r_col_pos != w_last_col);
            if (i_cmd == CMD_DRAIN) begin
                n_job.use_sample = 1'b0;
                n_job.has_up     = (w_last_row != '0);
                n_job.frame_end  = (r_col_pos == w_last_col);
                n_job.count      = CNT_W'(1) + CNT_W'(n_job.has_up)
                                   + CNT_W'(n_job.has_left) + CNT_W'(n_job.has_right);
                n_job_row        = w_last_row;
                if (r_draining) begin
                    w_go_work = 1'b1;
                    if (n_job.frame_end) begin
                        n_row_pos  = '0;
                        n_col_pos  = '0;
                        n_draining = 1'b0;
                    end else begin
                        n_col_pos = r_col_pos + COL_W'(1);
                    end
                end
            end else begin
                n_job.use_sample = 1'b1;
                n_job.has_up     = (int'(r_row_pos) >= 2);
                n_job.frame_end  = 1'b0;
                n_job.count      = CNT_W'(2) + CNT_W'(n_job.has_up)
                                   + CNT_W'(n_job.has_left) + CNT_W'(n_job.has_right);
                n_job_row        = r_row_pos - ROW_W'(1);
                if (!r_draining) begin
                    w_go_work  = (r_row_pos != '0);
                    w_go_write = (r_row_pos == '0);
                    if (r_col_pos == w_last_col) begin
                        n_col_pos = '0;
                        n_sel     = !r_sel;
                        if (r_row_pos == w_last_row) begin
                            n_row_pos  = '0;
                            n_draining = 1'b1;
                        end else begin
                            n_row_pos = r_row_pos + ROW_W'(1);
                        end
                    end else begin
                        n_col_pos = r_col_pos + COL_W'(1);
                    end
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_go_work) begin
                    n_state = ST_RD_C;
                end else if (w_go_write) begin
                    n_state = ST_WR;
                end
            end
            ST_RD_C:  n_state = ST_RD_L;
            ST_RD_L:  n_state = ST_RD_R;
            ST_RD_R:  n_state = ST_SUM_R;
            ST_SUM_R: n_state = ST_MUL;
            ST_MUL:   n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WR:    n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_stall           = (r_state != ST_IDLE) || i_cfg_valid;
        o_cfg_ready          = (r_state == ST_IDLE);
        o_dp_cmd             = '0;
        o_dp_cmd.job         = r_job;
        o_dp_cmd.load_sample = w_accept;
        o_rd_addr            = r_job_col;
        o_wr_addr            = r_job_col;
        unique case (r_state)
            ST_RD_C: begin
                o_dp_cmd.sum_init = 1'b1;
            end
            ST_RD_L: begin
                o_dp_cmd.acc_center = 1'b1;
                o_dp_cmd.wr_en      = r_job.use_sample;
                o_rd_addr           = r_job_col - COL_W'(1);
            end
            ST_RD_R: begin
                o_dp_cmd.acc_left = 1'b1;
                o_rd_addr         = r_job_col + COL_W'(1);
            end
            ST_SUM_R: o_dp_cmd.acc_right = 1'b1;
            ST_MUL:   o_dp_cmd.mul       = 1'b1;
            ST_FIN:   o_dp_cmd.fin       = w_out_free;
            ST_WR:    o_dp_cmd.wr_en     = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows      <= ROWS_RESET;
            r_cols      <= COLS_RESET;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_draining  <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_row_pos  <= n_row_pos;
            r_col_pos  <= n_col_pos;
            r_draining <= n_draining;
            r_sel      <= n_sel;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_job_row <= n_job_row;
        r_job_col <= n_job_col;
        if (w_load_out) begin
            r_out_row <= r_job_row;
            r_out_col <= r_job_col;
            r_out_fe  <= r_job.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_frame_end = r_out_fe;

endmodule

/* hdl/cross_mean_filter.sv */
// ----------------------------------------------------------------------------
// cross_mean_filter: five-point cross mean filter over a raster-order frame
// Averages each pixel with its in-frame up, down, left and right neighbors
// and reports the mean as unsigned fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
// Samples (cmd 0) arrive in raster order. The result for a pixel of row r is
// produced when the sample of row r+1 in the same column arrives, so the
// first row gives no results; after the last sample of the frame the block
// waits for drain words (cmd 1), each of which returns one pixel of the last
// row, and the last of which carries frame_end and restarts the frame. Drain
// words outside that phase and samples sent during it are accepted and
// dropped. The mean is floor(256 * sum / count), where the count of pixels
// used is 1 to 5 depending on the frame edges. Timing: one word is in work at
// a time. A word that yields a result occupies the block until its mean is
// registered, with any wait for a stalled output register to free up, because
// each line store has a single registered read port and three entries of the
// newest row are read one after another, followed by the reciprocal multiply
// and its correction step. A first-row sample holds it only for its store
// write, and a dropped word ends at acceptance. A finished result sits in an
// output register, so the next word is accepted while it waits.
// Writing either configuration register restarts the frame; the line stores
// keep their contents and need no clearing pass after reset. Configuration
// is accepted whenever no word is in work, and an input word offered in the
// same cycle as a configuration write is stalled until the write is done.
// ----------------------------------------------------------------------------
module cross_mean_filter #(
    parameter int MAX_COLS = cmf_pkg::CMF_MAX_COLS,
    parameter int MAX_ROWS = cmf_pkg::CMF_MAX_ROWS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input words.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_cmd,
    input  logic [cmf_pkg::SAMPLE_W-1:0]          i_sample,
    // Result words.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [cmf_pkg::MEAN_W-1:0]            o_mean_value,
    output logic [cmf_pkg::addr_w(MAX_ROWS)-1:0]  o_out_row,
    output logic [cmf_pkg::addr_w(MAX_COLS)-1:0]  o_out_col,
    output logic                                  o_frame_end,
    // Configuration writes: index 0 is rows_in_use, index 1 is cols_in_use.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cmf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cmf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import cmf_pkg::*;

    localparam int COL_W = addr_w(MAX_COLS);

    t_dp_cmd          w_dp_cmd;
    logic [COL_W-1:0] w_rd_addr;
    logic [COL_W-1:0] w_wr_addr;

    // The controller tracks the frame position and steps the datapath.
    cmf_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end),
        .o_dp_cmd    (w_dp_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr)
    );

    // The datapath holds both line stores and computes the mean.
    cmf_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_sample     (i_sample),
        .i_cmd        (w_dp_cmd),
        .i_rd_addr    (w_rd_addr),
        .i_wr_addr    (w_wr_addr),
        .o_mean_value (o_mean_value)
    );

endmodule
